@@ hdl/pbsc_pkg.sv @@
// Shared types, register codes and constants for the PID balance speed controller.
`timescale 1ns / 1ps

package pbsc_pkg;

  // Default width of the incoming pitch sample
  localparam int SampleWidthDef = 16;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 18;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CfgPropGain  = 3'd0,
    CfgIntegGain = 3'd1,
    CfgDerivGain = 3'd2,
    CfgSetpoint  = 3'd3,
    CfgSumLimit  = 3'd4,
    CfgCeiling   = 3'd5,
    CfgFloor     = 3'd6,
    CfgRevThresh = 3'd7
  } cfg_idx_e;

  // Item kinds
  localparam logic FuncSample = 1'b0;
  localparam logic FuncTick   = 1'b1;

  typedef struct packed {
    logic        [15:0] prop_gain;
    logic        [15:0] integ_gain;
    logic        [15:0] deriv_gain;
    logic signed [15:0] pitch_setpoint;
    logic        [17:0] sum_limit;
    logic        [14:0] speed_ceiling;
    logic        [14:0] speed_floor;
    logic signed [16:0] reverse_threshold;
  } cfg_t;

  localparam logic        [15:0] PropGainRst  = 16'd12288;
  localparam logic        [15:0] IntegGainRst = 16'd410;
  localparam logic        [15:0] DerivGainRst = 16'd3277;
  localparam logic signed [15:0] SetpointRst  = 16'sd0;
  localparam logic        [17:0] SumLimitRst  = 18'd131072;
  localparam logic        [14:0] CeilingRst   = 15'd13107;
  localparam logic        [14:0] FloorRst     = 15'd6554;
  localparam logic signed [16:0] RevThreshRst = 17'sd4655;

  // Error is held in Q2.15, 18 bits signed
  localparam int ErrW   = 18;
  localparam int ErrMax = 131071;
  localparam int ErrMin = -131072;

  // Sum and difference in Q3.15, 19 bits signed
  localparam int SumW = 19;
  // Gain x operand products, and their total
  localparam int ProdW = 36;
  localparam int CorrW = 37;

  localparam int SpeedW = 16;
  localparam logic [15:0] OutMax = 16'd32767;

  // x / 5 as (x * Div5Recip) >> Div5Shift, exact for x below 2^21 / 3
  localparam logic [20:0] Div5Recip = 21'd419431;
  localparam int          Div5Shift = 21;

endpackage

@@ hdl/pid_balance_speed_controller.sv @@
// Top level of the PID balance speed controller: sample/tick pipeline and state.
//
//  channel   signals                                     direction
//  --------  ------------------------------------------  ---------
//  in        in_valid_i/in_ready_o, func_i, pitch_sample_i  in
//  out       out_valid_o/out_ready_i, drive_velocity_o     out
//  cfg       cfg_we_i, cfg_idx_i, cfg_wdata_i              in
//
// One beat per cycle is taken unless the output stalls; input, error/sum and gain
// product registers sit ahead of the output register; a tick passes them all
// before out_valid_o rises. Samples give no result beat. Error state is updated
// as an item leaves the input register and speed as it leaves the product stage,
// so every item sees the state of the items before it. Reset clears valid flags
// and state; a stalled output beat holds while the stages behind it keep filling.
`timescale 1ns / 1ps

module pid_balance_speed_controller #(
  parameter int SAMPLE_WIDTH = pbsc_pkg::SampleWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic signed [SAMPLE_WIDTH-1:0] pitch_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [15:0]            drive_velocity_o,
  input  logic                          cfg_we_i,
  input  logic [pbsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pbsc_pkg::CfgDataW-1:0] cfg_wdata_i
);

  // Width that holds setpoint - pitch and the error limits
  localparam int CW = (SAMPLE_WIDTH + 1 > pbsc_pkg::ErrW) ? SAMPLE_WIDTH + 1 : pbsc_pkg::ErrW;
  localparam int EW = pbsc_pkg::ErrW;
  localparam int SW = pbsc_pkg::SumW;
  localparam int PW = pbsc_pkg::ProdW;
  localparam int RW = pbsc_pkg::CorrW;
  localparam int VW = pbsc_pkg::SpeedW;
  localparam logic signed [CW-1:0] ErrMaxC = CW'(pbsc_pkg::ErrMax);
  localparam logic signed [CW-1:0] ErrMinC = CW'(pbsc_pkg::ErrMin);

  pbsc_pkg::cfg_t cfg;

  pbsc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // Stage valids and flow control
  logic v1_q, v2_q, v3_q, out_valid_q;
  logic rdy1, rdy2, rdy3;

  logic                          func1_q, func2_q, func3_q;
  logic signed [SAMPLE_WIDTH-1:0] pitch1_q;
  logic                          rev2_q, rev3_q;
  logic signed [EW-1:0]          err2_q;
  logic signed [SW-1:0]          diff2_q, sum2_q;
  logic signed [PW-1:0]          pp3_q, pi3_q, pd3_q;

  // Controller state
  logic signed [EW-1:0] last_err_q;
  logic signed [SW-1:0] err_sum_q;
  logic [VW-1:0]        speed_q, speed_d;
  logic signed [15:0]   drive_q, drive_d;

  assign rdy3 = !v3_q || (func3_q == pbsc_pkg::FuncSample) || !out_valid_q || out_ready_i;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  // Stage 1: error, difference, clamped sum and reverse flag
  logic signed [CW-1:0] raw_err;
  logic signed [EW-1:0] err;
  logic signed [SW-1:0] diff, sum;
  logic signed [SW:0]   sum_raw, lim;
  logic                 rev;

  always_comb begin
    raw_err = CW'(cfg.pitch_setpoint) - CW'(pitch1_q);
    if (raw_err > ErrMaxC) begin
      err = EW'(pbsc_pkg::ErrMax);
    end else if (raw_err < ErrMinC) begin
      err = EW'(pbsc_pkg::ErrMin);
    end else begin
      err = raw_err[EW-1:0];
    end
    diff    = SW'(err) - SW'(last_err_q);
    sum_raw = (SW+1)'(err_sum_q) + (SW+1)'(err);
    lim     = $signed({2'b00, cfg.sum_limit});
    if (sum_raw > lim) begin
      sum = lim[SW-1:0];
    end else if (sum_raw < -lim) begin
      sum = SW'(-lim);
    end else begin
      sum = sum_raw[SW-1:0];
    end
    rev = last_err_q >= EW'(cfg.reverse_threshold);
  end

  // Stage 2: gain products
  logic signed [16:0] kp_s, ki_s, kd_s;
  assign kp_s = $signed({1'b0, cfg.prop_gain});
  assign ki_s = $signed({1'b0, cfg.integ_gain});
  assign kd_s = $signed({1'b0, cfg.deriv_gain});

  // Stage 3: correction magnitude, limits, and the tick result
  logic signed [RW-1:0] corr;
  logic [RW-1:0]        mag, ceil27, floor27;
  logic [VW+3:0]        speed9;
  logic [VW+24:0]       div_prod;
  logic [VW:0]          fwd;

  always_comb begin
    corr    = RW'(pp3_q) + RW'(pd3_q) + RW'(pi3_q);
    mag     = corr[RW-1] ? RW'(-corr) : RW'(corr);
    ceil27  = RW'({cfg.speed_ceiling, 12'b0});
    floor27 = RW'({cfg.speed_floor, 12'b0});
    if (mag > ceil27) begin
      speed_d = VW'(cfg.speed_ceiling);
    end else if (mag < floor27) begin
      speed_d = VW'(cfg.speed_floor);
    end else begin
      speed_d = mag[VW+11:12];
    end

    // 1.8 * speed = (speed * 9) / 5, saturated
    speed9   = (VW+4)'({speed_q, 3'b000}) + (VW+4)'(speed_q);
    div_prod = (VW+25)'(speed9) * (VW+25)'(pbsc_pkg::Div5Recip);
    fwd      = div_prod[pbsc_pkg::Div5Shift +: VW+1];
    if (rev3_q) begin
      drive_d = $signed(16'(17'd0 - {1'b0, speed_q}));
    end else if (fwd > (VW+1)'(pbsc_pkg::OutMax)) begin
      drive_d = $signed(pbsc_pkg::OutMax);
    end else begin
      drive_d = $signed(fwd[15:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
      last_err_q  <= '0;
      err_sum_q   <= '0;
      speed_q     <= '0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;

      if (v1_q && rdy2 && func1_q == pbsc_pkg::FuncSample) begin
        last_err_q <= err;
        err_sum_q  <= sum;
      end
      if (v3_q && rdy3 && func3_q == pbsc_pkg::FuncSample) begin
        speed_q <= speed_d;
      end

      if (v3_q && rdy3 && func3_q == pbsc_pkg::FuncTick) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && rdy1) begin
      func1_q  <= func_i;
      pitch1_q <= pitch_sample_i;
    end
    if (v1_q && rdy2) begin
      func2_q <= func1_q;
      rev2_q  <= rev;
      err2_q  <= err;
      diff2_q <= diff;
      sum2_q  <= sum;
    end
    if (v2_q && rdy3) begin
      func3_q <= func2_q;
      rev3_q  <= rev2_q;
      pp3_q   <= PW'(kp_s) * PW'(err2_q);
      pd3_q   <= PW'(kd_s) * PW'(diff2_q);
      pi3_q   <= PW'(ki_s) * PW'(sum2_q);
    end
    if (v3_q && rdy3 && func3_q == pbsc_pkg::FuncTick) begin
      drive_q <= drive_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign drive_velocity_o = drive_q;

endmodule

@@ hdl/pbsc_cfg_regs.sv @@
// Configuration register file of the PID balance speed controller.
`timescale 1ns / 1ps

module pbsc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pbsc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pbsc_pkg::CfgDataW-1:0] cfg_wdata_i,
  output pbsc_pkg::cfg_t                cfg_o
);

  pbsc_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (pbsc_pkg::cfg_idx_e'(cfg_idx_i))
        pbsc_pkg::CfgPropGain:  cfg_d.prop_gain         = cfg_wdata_i[15:0];
        pbsc_pkg::CfgIntegGain: cfg_d.integ_gain        = cfg_wdata_i[15:0];
        pbsc_pkg::CfgDerivGain: cfg_d.deriv_gain        = cfg_wdata_i[15:0];
        pbsc_pkg::CfgSetpoint:  cfg_d.pitch_setpoint    = $signed(cfg_wdata_i[15:0]);
        pbsc_pkg::CfgSumLimit:  cfg_d.sum_limit         = cfg_wdata_i[17:0];
        pbsc_pkg::CfgCeiling:   cfg_d.speed_ceiling     = cfg_wdata_i[14:0];
        pbsc_pkg::CfgFloor:     cfg_d.speed_floor       = cfg_wdata_i[14:0];
        pbsc_pkg::CfgRevThresh: cfg_d.reverse_threshold = $signed(cfg_wdata_i[16:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain         <= pbsc_pkg::PropGainRst;
      cfg_q.integ_gain        <= pbsc_pkg::IntegGainRst;
      cfg_q.deriv_gain        <= pbsc_pkg::DerivGainRst;
      cfg_q.pitch_setpoint    <= pbsc_pkg::SetpointRst;
      cfg_q.sum_limit         <= pbsc_pkg::SumLimitRst;
      cfg_q.speed_ceiling     <= pbsc_pkg::CeilingRst;
      cfg_q.speed_floor       <= pbsc_pkg::FloorRst;
      cfg_q.reverse_threshold <= pbsc_pkg::RevThreshRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ test/tb_pid_balance_speed_controller.sv @@
// Self-checking testbench for the PID balance speed controller: directed and random traffic.
`timescale 1ns / 1ps

module tb_pid_balance_speed_controller;

  logic                          clk          = 1'b0;
  logic                          rst_n        = 1'b0;
  logic                          in_valid     = 1'b0;
  logic                          in_ready;
  logic                          func         = pbsc_pkg::FuncSample;
  logic signed [15:0]            pitch_sample = '0;
  logic                          out_valid;
  logic                          out_ready    = 1'b0;
  logic signed [15:0]            drive_velocity;
  logic                          cfg_we       = 1'b0;
  logic [pbsc_pkg::CfgIdxW-1:0]  cfg_idx      = '0;
  logic [pbsc_pkg::CfgDataW-1:0] cfg_wdata    = '0;

  // Controller mirror: registers and state as the block should hold them
  pbsc_pkg::cfg_t pid_cfg;
  int   last_err  = 0;
  int   err_sum   = 0;
  int   speed_mag = 0;

  logic signed [15:0] pending_drive_q[$];
  logic signed [15:0] want_drive;
  int                 n_errors = 0;

  int          send_gap_pct   = 0;
  int          recv_stall_pct = 0;
  int unsigned hold_reqs      = 0;
  int unsigned hold_served    = 0;
  int          hold_len       = 0;

  pid_balance_speed_controller u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .func_i          (func),
    .pitch_sample_i  (pitch_sample),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .drive_velocity_o(drive_velocity),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sample: update error, clamped sum and speed magnitude
  function automatic void absorb_pitch(logic signed [15:0] pitch);
    int     err;
    int     diff;
    int     lim;
    int     sum;
    longint corr;
    longint mag;
    longint ceil_q27;
    longint floor_q27;
    err = int'($signed(pid_cfg.pitch_setpoint)) - int'(pitch);
    if (err > pbsc_pkg::ErrMax) err = pbsc_pkg::ErrMax;
    if (err < pbsc_pkg::ErrMin) err = pbsc_pkg::ErrMin;
    diff = err - last_err;
    lim  = int'(pid_cfg.sum_limit);
    sum  = err_sum + err;
    if (sum > lim) sum = lim;
    else if (sum < -lim) sum = -lim;
    corr = longint'(pid_cfg.prop_gain) * err + longint'(pid_cfg.deriv_gain) * diff
         + longint'(pid_cfg.integ_gain) * sum;
    mag       = (corr < 0) ? -corr : corr;
    ceil_q27  = longint'(pid_cfg.speed_ceiling) << 12;
    floor_q27 = longint'(pid_cfg.speed_floor) << 12;
    // ceiling wins over floor when the two are crossed
    if (mag > ceil_q27) speed_mag = int'(pid_cfg.speed_ceiling);
    else if (mag < floor_q27) speed_mag = int'(pid_cfg.speed_floor);
    else speed_mag = int'(mag >> 12);
    last_err = err;
    err_sum  = sum;
  endfunction

  // Tick: reverse at or above threshold, else 1.8x forward with saturation
  function automatic logic signed [15:0] tick_drive();
    int v;
    if (last_err >= int'($signed(pid_cfg.reverse_threshold))) begin
      v = -speed_mag;
    end else begin
      v = (speed_mag * 9) / 5;
      if (v > int'(pbsc_pkg::OutMax)) v = int'(pbsc_pkg::OutMax);
    end
    return v[15:0];
  endfunction

  // Receiver: random stalls, plus long hold-offs on request
  initial begin : receiver
    int left;
    left = 0;
    forever begin
      @(posedge clk);
      if (left == 0 && hold_reqs != hold_served) begin
        hold_served++;
        left = hold_len;
      end
      if (left > 0) begin
        left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_drive_q.size() == 0) begin
        $error("drive_velocity: no beat expected, got %0d", drive_velocity);
        n_errors++;
      end else begin
        want_drive = pending_drive_q.pop_front();
        if (drive_velocity !== want_drive) begin
          $error("drive_velocity: expected %0d, got %0d", want_drive, drive_velocity);
          n_errors++;
        end
      end
    end
  end

  task automatic send_item(input logic kind, input logic signed [15:0] pitch);
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
    end
    in_valid     <= 1'b1;
    func         <= kind;
    pitch_sample <= pitch;
    do @(posedge clk); while (!in_ready);
    if (kind == pbsc_pkg::FuncTick) pending_drive_q.push_back(tick_drive());
    else absorb_pitch(pitch);
  endtask

  // Stop sending, let every expected beat arrive and the pipe empty of samples
  task automatic wait_quiet();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_drive_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input pbsc_pkg::cfg_idx_e idx,
                           input logic [pbsc_pkg::CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      pbsc_pkg::CfgPropGain:  pid_cfg.prop_gain         = data[15:0];
      pbsc_pkg::CfgIntegGain: pid_cfg.integ_gain        = data[15:0];
      pbsc_pkg::CfgDerivGain: pid_cfg.deriv_gain        = data[15:0];
      pbsc_pkg::CfgSetpoint:  pid_cfg.pitch_setpoint    = data[15:0];
      pbsc_pkg::CfgSumLimit:  pid_cfg.sum_limit         = data[17:0];
      pbsc_pkg::CfgCeiling:   pid_cfg.speed_ceiling     = data[14:0];
      pbsc_pkg::CfgFloor:     pid_cfg.speed_floor       = data[14:0];
      pbsc_pkg::CfgRevThresh: pid_cfg.reverse_threshold = data[16:0];
      default: ;
    endcase
  endtask

  // Random shift gives small values often, so speeds land between the limits too
  task automatic cfg_randomise();
    pbsc_pkg::cfg_idx_e r;
    r = r.first();
    do begin
      case ($urandom_range(7))
        0:       cfg_write(r, '0);
        1:       cfg_write(r, '1);
        2:       ;
        default: cfg_write(r, pbsc_pkg::CfgDataW'($urandom() >> $urandom_range(31, 14)));
      endcase
      r = r.next();
    end while (r != r.first());
  endtask

  task automatic send_random(input int count);
    logic signed [15:0] p;
    repeat (count) begin
      p = $urandom();
      if ($urandom_range(9) < 4) begin
        send_item(pbsc_pkg::FuncTick, p);
      end else begin
        // half of the samples sit near the setpoint
        if ($urandom_range(1)) p = pid_cfg.pitch_setpoint + 16'($urandom_range(4096)) - 16'd2048;
        send_item(pbsc_pkg::FuncSample, p);
      end
    end
  endtask

  task automatic test_tick_after_reset();
    send_item(pbsc_pkg::FuncTick, 16'sh7fff);
    wait_quiet();
    cfg_write(pbsc_pkg::CfgRevThresh, '0);
    send_item(pbsc_pkg::FuncTick, -16'sd1);
    wait_quiet();
    cfg_write(pbsc_pkg::CfgRevThresh, 18'(pbsc_pkg::RevThreshRst));
  endtask

  task automatic test_directed();
    send_item(pbsc_pkg::FuncSample, 16'sh7fff);
    send_item(pbsc_pkg::FuncTick, '0);
    send_item(pbsc_pkg::FuncSample, -16'sh8000);
    send_item(pbsc_pkg::FuncTick, '0);
    send_item(pbsc_pkg::FuncSample, -16'sd3000);
    send_item(pbsc_pkg::FuncTick, '0);
    send_item(pbsc_pkg::FuncSample, -16'sd1);
    send_item(pbsc_pkg::FuncTick, '0);
    wait_quiet();
    // crossed limits: ceiling under floor
    cfg_write(pbsc_pkg::CfgCeiling, 18'd100);
    cfg_write(pbsc_pkg::CfgFloor, 18'd20000);
    send_item(pbsc_pkg::FuncSample, -16'sh8000);
    send_item(pbsc_pkg::FuncTick, '0);
    send_item(pbsc_pkg::FuncSample, 16'sd0);
    send_item(pbsc_pkg::FuncTick, '0);
    wait_quiet();
    // forward drive saturates at full speed
    cfg_write(pbsc_pkg::CfgCeiling, 18'h7fff);
    cfg_write(pbsc_pkg::CfgFloor, 18'h7fff);
    cfg_write(pbsc_pkg::CfgRevThresh, 18'h0ffff);
    cfg_write(pbsc_pkg::CfgSetpoint, 18'h08000);
    send_item(pbsc_pkg::FuncSample, 16'sh7fff);
    send_item(pbsc_pkg::FuncTick, '0);
    wait_quiet();
    cfg_write(pbsc_pkg::CfgRevThresh, 18'h10000);
    cfg_write(pbsc_pkg::CfgPropGain, '1);
    cfg_write(pbsc_pkg::CfgIntegGain, '1);
    cfg_write(pbsc_pkg::CfgDerivGain, '1);
    cfg_write(pbsc_pkg::CfgSumLimit, '1);
    cfg_write(pbsc_pkg::CfgSetpoint, 18'h07fff);
    cfg_write(pbsc_pkg::CfgFloor, '0);
    send_item(pbsc_pkg::FuncSample, -16'sh8000);
    send_item(pbsc_pkg::FuncTick, '0);
    send_item(pbsc_pkg::FuncSample, -16'sh8000);
    send_item(pbsc_pkg::FuncTick, '0);
    wait_quiet();
    cfg_write(pbsc_pkg::CfgPropGain, '0);
    cfg_write(pbsc_pkg::CfgIntegGain, '0);
    cfg_write(pbsc_pkg::CfgDerivGain, '0);
    cfg_write(pbsc_pkg::CfgSumLimit, '0);
    cfg_write(pbsc_pkg::CfgFloor, 18'd1234);
    send_item(pbsc_pkg::FuncSample, 16'sh7fff);
    send_item(pbsc_pkg::FuncTick, '0);
    wait_quiet();
  endtask

  task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int items);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    repeat (items / 50) begin
      wait_quiet();
      cfg_randomise();
      send_random(50);
    end
    wait_quiet();
  endtask

  // Output held off while the sender keeps going, so the pipe backs up
  task automatic test_backpressure();
    logic signed [15:0] p;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    hold_len       = 300;
    hold_reqs++;
    repeat (60) begin
      p = $urandom();
      send_item(($urandom_range(9) < 7) ? pbsc_pkg::FuncTick : pbsc_pkg::FuncSample, p);
    end
    wait_quiet();
  endtask

  initial begin
    pid_cfg = '{pbsc_pkg::PropGainRst, pbsc_pkg::IntegGainRst, pbsc_pkg::DerivGainRst,
                pbsc_pkg::SetpointRst, pbsc_pkg::SumLimitRst, pbsc_pkg::CeilingRst,
                pbsc_pkg::FloorRst, pbsc_pkg::RevThreshRst};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_tick_after_reset();
    test_directed();
    test_random_traffic(16, 67, 300);
    test_random_traffic(67, 16, 300);
    test_random_traffic(0, 0, 300);
    test_backpressure();
    wait_quiet();
    repeat (10) @(posedge clk);
    if (n_errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/pbsc_pkg.sv
hdl/pbsc_cfg_regs.sv
hdl/pid_balance_speed_controller.sv
test/tb_pid_balance_speed_controller.sv
